// File: sv/qdbp_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes, select codes and the frame type of the beam position block.
package qdbp_pkg;

	localparam int NUM_CH   = 4;
	localparam int NUM_AX   = 2;
	localparam int CH_IDX_W = $clog2(NUM_CH);

	localparam int SAMPLE_W = 16;
	localparam int SEL_W    = 2;
	localparam int OFF_W    = 17;
	localparam int CUR_W    = 18;
	localparam int SUM_W    = 19;
	localparam int DIFF_W   = 19;
	localparam int POS_W    = 34;

	localparam int IN_W  = 2 * NUM_CH * SAMPLE_W;
	localparam int OUT_W = NUM_CH * CUR_W + NUM_AX * (SUM_W + DIFF_W + POS_W);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_SELECT_CH0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH0 = 3'd4;

	localparam logic [SEL_W-1:0] SEL_PING = 2'd0;
	localparam logic [SEL_W-1:0] SEL_PONG = 2'd1;

	localparam int unsigned POSITION_SCALE = 32767;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Currents, sums and differences of one frame; current_ch0 sits in the lowest bits.
	typedef struct packed {
		logic [NUM_AX-1:0][DIFF_W-1:0] diff;
		logic [NUM_AX-1:0][SUM_W-1:0]  sum;
		logic [NUM_CH-1:0][CUR_W-1:0]  cur;
	} item_t;

endpackage

// File: sv/qdbp_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, source select, offset removal, axis sum and difference.
module qdbp_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [qdbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qdbp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [qdbp_pkg::IN_W-1:0]          s_tdata,
	output logic                               push,
	output qdbp_pkg::item_t                    push_item,
	input  logic                               full
);
	import qdbp_pkg::*;

	logic [NUM_CH-1:0][SEL_W-1:0] sel_q;
	logic [NUM_CH-1:0][OFF_W-1:0] off_q;

	logic                         vld_s1;
	logic [NUM_CH-1:0][CUR_W-1:0] cur_s1;
	logic                         vld_s2;
	item_t                        item_s2;

	logic                         front_adv;
	logic [NUM_CH-1:0][CUR_W-1:0] cur_d;
	item_t                        item_d;

	assign front_adv = !vld_s2 || !full;
	assign s_tready  = front_adv;
	assign push      = vld_s2 && !full;
	assign push_item = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
			off_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index >= REG_OFFSET_CH0) begin
				off_q[CH_IDX_W'(cfg_index - REG_OFFSET_CH0)] <= cfg_data[OFF_W-1:0];
			end else begin
				sel_q[CH_IDX_W'(cfg_index - REG_SELECT_CH0)] <= cfg_data[SEL_W-1:0];
			end
		end
	end

	always_comb begin
		logic [SAMPLE_W-1:0] ping;
		logic [SAMPLE_W-1:0] pong;
		logic [SAMPLE_W:0]   pair;
		logic [SAMPLE_W-1:0] pick;
		for (int c = 0; c < NUM_CH; c++) begin
			ping = s_tdata[2*c*SAMPLE_W +: SAMPLE_W];
			pong = s_tdata[(2*c+1)*SAMPLE_W +: SAMPLE_W];
			pair = {1'b0, ping} + {1'b0, pong};
			unique case (sel_q[c])
				SEL_PING: pick = ping;
				SEL_PONG: pick = pong;
				default:  pick = pair[SAMPLE_W:1];
			endcase
			cur_d[c] = {2'b00, pick} - {off_q[c][OFF_W-1], off_q[c]};
		end
	end

	always_comb begin
		logic [SUM_W-1:0] s;
		item_d.cur = cur_s1;
		for (int a = 0; a < NUM_AX; a++) begin
			s = {cur_s1[a][CUR_W-1], cur_s1[a]} + {cur_s1[a+NUM_AX][CUR_W-1], cur_s1[a+NUM_AX]};
			// replace a zero sum by one, both for the division and the report
			item_d.sum[a]  = (s == '0) ? SUM_W'(1) : s;
			item_d.diff[a] = {cur_s1[a+NUM_AX][CUR_W-1], cur_s1[a+NUM_AX]}
			                 - {cur_s1[a][CUR_W-1], cur_s1[a]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (front_adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (front_adv) begin
			cur_s1  <= cur_d;
			item_s2 <= item_d;
		end
	end

endmodule

// File: sv/qdbp_queue.sv
`timescale 1ns / 1ps
// Short frame queue between the front end and the divider back end.
module qdbp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  qdbp_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output qdbp_pkg::item_t head_item,
	output logic            empty
);
	import qdbp_pkg::*;

	item_t             ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign empty     = (count_q == '0);
	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_item = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_item;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue fill count exceeds depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");

endmodule

// File: sv/qdbp_back.sv
`timescale 1ns / 1ps
// Back end: scaling, pipelined restoring divider for both axes, and the output register.
module qdbp_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  qdbp_pkg::item_t           head_item,
	input  logic                      empty,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [qdbp_pkg::OUT_W-1:0] m_tdata
);
	import qdbp_pkg::*;

	localparam int SCALE_W    = $clog2(POSITION_SCALE + 1);
	localparam int NUM_W      = DIFF_W - 1 + SCALE_W;
	localparam int DEN_W      = SUM_W - 1;
	localparam int REM_W      = DEN_W + 1;
	localparam int BPS        = 3;
	localparam int DIV_STAGES = (NUM_W + BPS - 1) / BPS;
	localparam int DIV_W      = DIV_STAGES * BPS;

	// numerator bits shift out at the top while quotient bits shift in at the bottom
	typedef struct packed {
		logic [DIV_W-1:0] nq;
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic             neg;
	} ax_t;

	typedef struct packed {
		item_t                  item;
		ax_t [NUM_AX-1:0]       ax;
	} div_t;

	function automatic ax_t div_step(input ax_t d);
		ax_t              r;
		logic [REM_W-1:0] shifted;
		logic [REM_W:0]   trial;
		r = d;
		for (int b = 0; b < BPS; b++) begin
			shifted = {r.rem, r.nq[DIV_W-1]};
			trial   = {1'b0, shifted} - {2'b00, r.den};
			if (!trial[REM_W]) begin
				r.rem = trial[DEN_W-1:0];
				r.nq  = {r.nq[DIV_W-2:0], 1'b1};
			end else begin
				r.rem = shifted[DEN_W-1:0];
				r.nq  = {r.nq[DIV_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	logic                           back_adv;
	logic                           vld_s1;
	div_t                           prep_s1;
	logic [DIV_STAGES-1:0]          div_vld_s2;
	div_t                           div_s2 [DIV_STAGES];
	logic                           vld_s3;
	item_t                          res_item_s3;
	logic [NUM_AX-1:0][POS_W-1:0]   res_pos_s3;

	div_t                           prep_d;
	div_t                           div_d [DIV_STAGES];
	logic [NUM_AX-1:0][POS_W-1:0]   pos_d;

	// hold every stage while the output word waits
	assign back_adv = !vld_s3 || m_tready;
	assign pop      = !empty && back_adv;
	assign m_tvalid = vld_s3;
	assign m_tdata  = {res_pos_s3, res_item_s3};

	always_comb begin
		logic [DIFF_W-1:0] d;
		logic [SUM_W-1:0]  s;
		logic [DIFF_W-1:0] abs_d;
		logic [SUM_W-1:0]  abs_s;
		prep_d.item = head_item;
		for (int a = 0; a < NUM_AX; a++) begin
			d     = head_item.diff[a];
			s     = head_item.sum[a];
			abs_d = d[DIFF_W-1] ? -d : d;
			abs_s = s[SUM_W-1] ? -s : s;
			prep_d.ax[a].nq  = DIV_W'(NUM_W'(abs_d[DIFF_W-2:0]) * NUM_W'(POSITION_SCALE));
			prep_d.ax[a].rem = '0;
			prep_d.ax[a].den = abs_s[DEN_W-1:0];
			prep_d.ax[a].neg = d[DIFF_W-1] ^ s[SUM_W-1];
		end
	end

	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			div_d[k] = (k == 0) ? prep_s1 : div_s2[(k == 0) ? 0 : k - 1];
			for (int a = 0; a < NUM_AX; a++) begin
				div_d[k].ax[a] = div_step(div_d[k].ax[a]);
			end
		end
	end

	always_comb begin
		logic [POS_W-1:0] q;
		for (int a = 0; a < NUM_AX; a++) begin
			q        = POS_W'(div_s2[DIV_STAGES-1].ax[a].nq);
			pos_d[a] = div_s2[DIV_STAGES-1].ax[a].neg ? -q : q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			div_vld_s2 <= '0;
			vld_s3     <= 1'b0;
		end else if (back_adv) begin
			vld_s1     <= !empty;
			div_vld_s2 <= {div_vld_s2[DIV_STAGES-2:0], vld_s1};
			vld_s3     <= div_vld_s2[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (back_adv) begin
			prep_s1 <= prep_d;
			for (int k = 0; k < DIV_STAGES; k++) begin
				div_s2[k] <= div_d[k];
			end
			res_item_s3 <= div_s2[DIV_STAGES-1].item;
			res_pos_s3  <= pos_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (prep_s1.ax[0].den != '0 && prep_s1.ax[1].den != '0))
		else $error("divider entered with a zero divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_s2[DIV_STAGES-1] |->
			(div_s2[DIV_STAGES-1].ax[0].rem < div_s2[DIV_STAGES-1].ax[0].den &&
			 div_s2[DIV_STAGES-1].ax[1].rem < div_s2[DIV_STAGES-1].ax[1].den))
		else $error("divider remainder not below divisor");

endmodule

// File: sv/quad_diode_beam_position.sv
`timescale 1ns / 1ps
// Top level of the quadrant diode beam position block, difference over sum.
//
// Each input word carries one frame of eight 16-bit samples, a ping and a pong sample for
// each of four diode channels. Per channel, the select register picks ping (0), pong (1) or
// their average rounded down (2; code 3 also averages), and the signed 17-bit offset is
// subtracted to give the current. Axis 0 pairs channels 0 and 2, axis 1 pairs channels 1
// and 3; each axis reports sum, difference (second minus first) and the position
// POSITION_SCALE * diff / sum, truncated toward zero. A zero sum is reported as 1 and used
// as 1 in the division. Throughput is one frame per clock while m_tready is high; the divider
// is fully pipelined, three quotient bits per stage. From an accepted input word to a valid
// output word the frame passes two front-end stages, one queue slot, one scaling stage, eleven
// divider stages and the output register. A two-word queue decouples front end and divider,
// so a stalled output fills the queue before s_tready drops. Write configuration only while
// no frame is in flight; no clearing pass follows reset.
module quad_diode_beam_position (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration: index 0..3 select_ch0..3, 4..7 offset_ch0..3
	input  logic                               cfg_we,
	input  logic [qdbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qdbp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// lowest bit up: ch0_ping, ch0_pong, ch1_ping, ch1_pong,
	// ch2_ping, ch2_pong, ch3_ping, ch3_pong (16 bits each)
	input  logic [qdbp_pkg::IN_W-1:0]          s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// lowest bit up: current_ch0..current_ch3 (18 each), sum_axis0, sum_axis1,
	// diff_axis0, diff_axis1 (19 each), pos_axis0, pos_axis1 (34 each)
	output logic [qdbp_pkg::OUT_W-1:0]         m_tdata
);
	import qdbp_pkg::*;

	logic  push;
	logic  full;
	logic  pop;
	logic  empty;
	item_t push_item;
	item_t head_item;

	// select and offset the channels, combine them per axis, then hand the frame to the queue
	qdbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	// hold frames while the divider stalls on the output side
	qdbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head_item (head_item),
		.empty     (empty)
	);

	// scale, divide and drive the output word
	qdbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (head_item),
		.empty     (empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
